/* rtl/core/signed_int_to_radix_symbols_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef SIGNED_INT_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH

// Same-cycle implication.
`define SRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/srs_pkg.sv */
`default_nettype none
package srs_pkg;

  localparam int NUMBER_W    = 32;
  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 4;
  localparam int WORD_COUNT  = 8;
  localparam int WORD_IDX_W  = 3;
  localparam int ADDR_W      = 6;
  localparam int DIGIT_W     = 6;
  localparam int DIV_STEPS   = 8;
  localparam int ALNUM_CODES = 62;
  localparam int MIN_RADIX   = 2;

  localparam logic [BYTE_W-1:0] SYM_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] SYM_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] SYM_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] SYM_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] SYM_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] SYM_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] SYM_MINUS   = 8'h2D;

  localparam logic [BYTE_W-1:0] CODE_UPPER_BASE = 8'd10;
  localparam logic [BYTE_W-1:0] CODE_LOWER_BASE = 8'd36;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic               done;
    logic               ok;
    logic [DIGIT_W-1:0] radix;
  } scan_res_t;

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    return ((c >= SYM_ZERO) && (c <= SYM_NINE)) ||
           ((c >= SYM_UPPER_A) && (c <= SYM_UPPER_Z)) ||
           ((c >= SYM_LOWER_A) && (c <= SYM_LOWER_Z));
  endfunction

  // Dense code 0..61 for a letter or digit.
  function automatic logic [DIGIT_W-1:0] sym_code(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    if (c <= SYM_NINE) begin
      v = c - SYM_ZERO;
    end else if (c <= SYM_UPPER_Z) begin
      v = c - SYM_UPPER_A + CODE_UPPER_BASE;
    end else begin
      v = c - SYM_LOWER_A + CODE_LOWER_BASE;
    end
    return v[DIGIT_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/srs_tbl_scan.sv */
`default_nettype none
module srs_tbl_scan import srs_pkg::*; #(
  parameter int TABLE_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [BYTE_W-1:0] tbl_byte,
  output logic      [ADDR_W-1:0] tbl_addr,
  output scan_res_t              res
);

  localparam int IDX_W = $clog2(TABLE_BYTES + 1);

  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   busy_r, busy_nxt;
  logic [ALNUM_CODES-1:0] seen_r, seen_nxt;
  scan_res_t              res_r, res_nxt;
  logic [DIGIT_W-1:0]     code;

  always_comb begin
    code     = sym_code(tbl_byte);
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    seen_nxt = seen_r;
    res_nxt  = res_r;
    res_nxt.done = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      seen_nxt = '0;
    end else if (busy_r) begin
      if (idx_r == IDX_W'(TABLE_BYTES)) begin
        busy_nxt      = 1'b0;
        res_nxt.done  = 1'b1;
        res_nxt.ok    = 1'b0;
        res_nxt.radix = '0;
      end else if (tbl_byte == '0) begin
        busy_nxt      = 1'b0;
        res_nxt.done  = 1'b1;
        res_nxt.ok    = (idx_r >= IDX_W'(MIN_RADIX));
        res_nxt.radix = DIGIT_W'(idx_r);
      end else if (!is_alnum(tbl_byte) || seen_r[code]) begin
        busy_nxt      = 1'b0;
        res_nxt.done  = 1'b1;
        res_nxt.ok    = 1'b0;
        res_nxt.radix = '0;
      end else begin
        seen_nxt[code] = 1'b1;
        idx_nxt        = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
      seen_r <= '0;
      res_r  <= '0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
      seen_r <= seen_nxt;
      res_r  <= res_nxt;
    end
  end

  assign tbl_addr = ADDR_W'(idx_r);
  assign res      = res_r;

endmodule
`default_nettype wire

/* rtl/core/srs_div_unit.sv */
`default_nettype none
module srs_div_unit import srs_pkg::*; #(
  parameter int QW = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [QW-1:0]      dividend,
  input  wire logic [DIGIT_W-1:0] divisor,
  output logic      [QW-1:0]      quotient,
  output logic      [DIGIT_W-1:0] remainder,
  output logic                    done
);

  localparam int PASSES = QW / DIV_STEPS;
  localparam int PASS_W = $clog2(PASSES + 1);

  logic [QW-1:0]      q_r, q_v;
  logic [DIGIT_W-1:0] rem_r, rem_v;
  logic [DIGIT_W:0]   r_v;
  logic [PASS_W-1:0]  pass_r;
  logic               busy_r;
  logic               done_r;

  // Eight restoring steps per pass.
  always_comb begin
    q_v   = q_r;
    rem_v = rem_r;
    r_v   = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r_v = {rem_v, q_v[QW-1]};
      q_v = {q_v[QW-2:0], 1'b0};
      if (r_v >= {1'b0, divisor}) begin
        r_v     = r_v - {1'b0, divisor};
        q_v[0]  = 1'b1;
      end
      rem_v = r_v[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pass_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pass_r <= '0;
      end else if (busy_r) begin
        pass_r <= pass_r + PASS_W'(1);
        if (pass_r == PASS_W'(PASSES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_v;
      rem_r <= rem_v;
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule
`default_nettype wire

/* rtl/core/srs_digit_stack.sv */
`default_nettype none
module srs_digit_stack import srs_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DIGIT_W-1:0]       wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DIGIT_W-1:0]       rd_data
);

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/signed_int_to_radix_symbols_top.sv */
// Channel  Dir  Handshake             Payload
// in       in   in_valid/in_ready     in_number[31:0] signed
// out      out  out_valid/out_ready   out_symbol[7:0], out_last
// cfg      in   cfg_valid/cfg_ready   cfg_index[3:0], cfg_data[63:0]
//
// One number at a time. The shared divider takes 8 quotient bits a cycle; each
// digit character takes a stack read and a table lookup. Synchronous rst_n clears
// control and the table. out_ready low while out_valid is high holds the
// sequencer at the next character; cfg_ready stays high.
`default_nettype none
module signed_int_to_radix_symbols_top import srs_pkg::*; #(
  parameter int TABLE_BYTES = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [NUMBER_W-1:0] in_number,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [BYTE_W-1:0]    out_symbol,
  output logic                      out_last
);

  localparam int QW    = ((VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int SAW   = $clog2(VALUE_WIDTH);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [CFG_W-1:0]       word_r [WORD_COUNT];
  logic [CFG_W-1:0]       tbl_word;
  logic [ADDR_W-1:0]      tbl_addr, scan_addr;
  logic [BYTE_W-1:0]      tbl_byte;

  seq_state_t             state_r, state_nxt;
  logic                   neg_r, neg_nxt;
  logic [QW-1:0]          mag_r, mag_nxt;
  logic [DIGIT_W-1:0]     radix_r, radix_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt, cnt_dec;
  logic                   out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]      out_symbol_r, out_symbol_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0] raw, mag_in;
  logic                   load_ok;

  scan_res_t              scan_res;
  logic                   scan_start;
  logic                   div_start, div_done;
  logic [QW-1:0]          div_dividend, div_quot;
  logic [DIGIT_W-1:0]     div_rem;
  logic                   stk_we, stk_re;
  logic [DIGIT_W-1:0]     stk_rdata;

  // Table words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < WORD_COUNT; w++) begin
        word_r[w] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < CFG_IDX_W'(WORD_COUNT))) begin
      word_r[cfg_index[WORD_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign tbl_addr  = (state_r == ST_SCAN) ? scan_addr : stk_rdata;
  assign tbl_word  = word_r[tbl_addr[ADDR_W-1:3]];
  assign tbl_byte  = tbl_word[{tbl_addr[2:0], 3'b000} +: BYTE_W];

  srs_tbl_scan #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .tbl_byte (tbl_byte),
    .tbl_addr (scan_addr),
    .res      (scan_res)
  );

  srs_div_unit #(
    .QW(QW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix_r),
    .quotient  (div_quot),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign cnt_dec = cnt_r - CNT_W'(1);

  srs_digit_stack #(
    .DEPTH(VALUE_WIDTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (cnt_r[SAW-1:0]),
    .wr_data (div_rem),
    .rd_en   (stk_re),
    .rd_addr (cnt_dec[SAW-1:0]),
    .rd_data (stk_rdata)
  );

  assign raw      = in_number[VALUE_WIDTH-1:0];
  assign mag_in   = raw[VALUE_WIDTH-1] ? ((~raw) + VALUE_WIDTH'(1)) : raw;
  assign in_ready = (state_r == ST_IDLE);
  assign load_ok  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    radix_nxt      = radix_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    scan_start     = 1'b0;
    div_start      = 1'b0;
    div_dividend   = div_quot;
    stk_we         = 1'b0;
    stk_re         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt    = raw[VALUE_WIDTH-1];
          mag_nxt    = QW'(mag_in);
          scan_start = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.ok) begin
            radix_nxt    = scan_res.radix;
            cnt_nxt      = '0;
            div_start    = 1'b1;
            div_dividend = mag_r;
            state_nxt    = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          stk_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (div_quot == '0) begin
            state_nxt = neg_r ? ST_SIGN : ST_READ;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (load_ok) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = SYM_MINUS;
          out_last_nxt   = 1'b0;
          state_nxt      = ST_READ;
        end
      end
      ST_READ: begin
        stk_re    = 1'b1;
        cnt_nxt   = cnt_dec;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_ok) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = tbl_byte;
          out_last_nxt   = (cnt_r == '0);
          state_nxt      = (cnt_r == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    radix_r      <= radix_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

/* rtl/core/srs_checker.sv */
`default_nettype none
`include "signed_int_to_radix_symbols_top_assert.svh"
module srs_checker import srs_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_symbol,
  input wire logic              out_last
);

  `SRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_symbol) && $stable(out_last), "out beat changed while stalled")
  `SRS_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
  `SRS_ASSERT_NEXT(a_no_out_on_in, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "beat right after accept")
  `SRS_ASSERT_SAME(a_minus_not_last, clk, rst_n, out_valid && (out_symbol == SYM_MINUS), !out_last, "minus sign marked last")

endmodule

bind signed_int_to_radix_symbols_top srs_checker u_chk (.*);
`default_nettype wire
